[src/setl_pkg.sv]
package setl_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int TIME_BITS   = 32;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int KIND_W     = 3;
   localparam int TYPE_W     = 4;
   localparam int TAG_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int FILL_W     = 7;
   localparam int REMOVED_W  = 6;
   localparam int TIME_IO_W  = 32;
   localparam int MASK_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_TIME_LSB = 0;
   localparam int REQ_TYPE_LSB = REQ_TIME_LSB + TIME_IO_W;
   localparam int REQ_TAG_LSB  = REQ_TYPE_LSB + TYPE_W;
   localparam int REQ_DATA_W   = ((REQ_TAG_LSB + TAG_W + 7) / 8) * 8;

   localparam int RSP_TIME_LSB = 0;
   localparam int RSP_TYPE_LSB = RSP_TIME_LSB + TIME_IO_W;
   localparam int RSP_TAG_LSB  = RSP_TYPE_LSB + TYPE_W;
   localparam int RSP_FILL_LSB = RSP_TAG_LSB + TAG_W;
   localparam int RSP_REM_LSB  = RSP_FILL_LSB + FILL_W;
   localparam int RSP_USED_W   = RSP_REM_LSB + REMOVED_W;
   localparam int RSP_DATA_W   = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = STATUS_W + 1;

   localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RM_ONE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RM_ALL  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEG_TIME = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOWED = 3'd4;

   localparam logic REG_SINGLE_MASK = 1'b0;
   localparam logic REG_MULTI_MASK  = 1'b1;

   localparam logic [MASK_W-1:0] SINGLE_MASK_RESET = 16'h3E40;
   localparam logic [MASK_W-1:0] MULTI_MASK_RESET  = 16'h0800;

   typedef struct packed {
      logic signed [TIME_BITS-1:0] ev_time;
      logic [TYPE_W-1:0]           ev_type;
      logic [TAG_W-1:0]            ev_tag;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      entry_type         wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic [MASK_W-1:0] single_mask;
      logic [MASK_W-1:0] multi_mask;
   } masks_type;

endpackage

[src/sorted_event_timeline.sv]
// channel   direction  beat contents
// req_      in         tuser: kind; tdata: event_time, event_type, event_tag
// rsp_      out        tuser: status, out_valid; tdata: head entry, fill, removed
// csr_      in         single_remove_mask at 0x0, multi_remove_mask at 0x4
//
// one item at a time; the queue is walked through the single read port of the
// entry memory, one entry a cycle, for add, pop and removals, and in two passes
// for replace (a drop pass, then an insert pass)
// reset empties the queue and restores both masks; no clearing pass
// a finished result waits in the output register while the next beat is taken
module sorted_event_timeline import setl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // event_time, event_type, event_tag
   input  logic [KIND_W-1:0]     req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_time, out_type, out_tag, fill_count, removed_count
   output logic [RSP_USER_W-1:0] rsp_tuser,  // status, out_valid
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   masks_type            masks;
   ram_req_type          ram_req;
   entry_type            ram_rdata;
   entry_type            req_entry;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_out_valid;
   entry_type            rsp_entry;
   logic [FILL_W-1:0]    rsp_fill;
   logic [REMOVED_W-1:0] rsp_removed;

   assign req_entry.ev_time = TIME_BITS'(req_tdata[REQ_TIME_LSB +: TIME_IO_W]);
   assign req_entry.ev_type = req_tdata[REQ_TYPE_LSB +: TYPE_W];
   assign req_entry.ev_tag  = req_tdata[REQ_TAG_LSB +: TAG_W];

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_TIME_LSB +: TIME_IO_W] = TIME_IO_W'(rsp_entry.ev_time);
      rsp_tdata[RSP_TYPE_LSB +: TYPE_W]    = rsp_entry.ev_type;
      rsp_tdata[RSP_TAG_LSB +: TAG_W]      = rsp_entry.ev_tag;
      rsp_tdata[RSP_FILL_LSB +: FILL_W]    = rsp_fill;
      rsp_tdata[RSP_REM_LSB +: REMOVED_W]  = rsp_removed;
   end

   assign rsp_tuser = {rsp_out_valid, rsp_status};

   setl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .masks       (masks)
   );

   setl_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (ram_rdata)
   );

   setl_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_kind      (req_tuser),
      .req_entry     (req_entry),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_out_valid (rsp_out_valid),
      .rsp_entry     (rsp_entry),
      .rsp_fill      (rsp_fill),
      .rsp_removed   (rsp_removed),
      .masks         (masks),
      .ram_req       (ram_req),
      .ram_rdata     (ram_rdata)
   );

endmodule

[src/setl_csr.sv]
module setl_csr import setl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output masks_type             masks
);

   masks_type masks_ff, masks_in;
   logic      wr_en;
   logic      reg_sel;

   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign masks      = masks_ff;

   always_comb begin
      masks_in = masks_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SINGLE_MASK: masks_in.single_mask = csr_pwdata[MASK_W-1:0];
            REG_MULTI_MASK:  masks_in.multi_mask  = csr_pwdata[MASK_W-1:0];
            default:         masks_in = masks_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SINGLE_MASK: csr_prdata = CSR_DATA_W'(masks_ff.single_mask);
         REG_MULTI_MASK:  csr_prdata = CSR_DATA_W'(masks_ff.multi_mask);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff.single_mask <= SINGLE_MASK_RESET;
         masks_ff.multi_mask  <= MULTI_MASK_RESET;
      end else begin
         masks_ff <= masks_in;
      end
   end

endmodule

[src/setl_ram.sv]
module setl_ram import setl_pkg::*; (
   input  logic        clock,
   input  ram_req_type ram_req,
   output entry_type   rdata
);

   entry_type mem [QUEUE_DEPTH];
   entry_type rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      rdata_ff <= mem[ram_req.raddr];
   end

endmodule

[src/setl_engine.sv]
module setl_engine import setl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [KIND_W-1:0]    req_kind,
   input  entry_type            req_entry,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_out_valid,
   output entry_type            rsp_entry,
   output logic [FILL_W-1:0]    rsp_fill,
   output logic [REMOVED_W-1:0] rsp_removed,
   input  masks_type            masks,
   output ram_req_type          ram_req,
   input  entry_type            ram_rdata
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_DROP      = 3'd2;
   localparam logic [2:0] S_INS_CHK   = 3'd3;
   localparam logic [2:0] S_INS       = 3'd4;
   localparam logic [2:0] S_HEAD_RD   = 3'd5;
   localparam logic [2:0] S_HEAD_WAIT = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   entry_type           new_ff, new_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    ri_ff, ri_in;
   logic                dv_ff, dv_in;
   logic [ADDR_W-1:0]   di_ff, di_in;
   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [ADDR_W-1:0]   rm_ff, rm_in;
   logic                lock_ff, lock_in;
   logic                ins_done_ff, ins_done_in;
   entry_type           carry_ff, carry_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_have_ff, res_have_in;
   entry_type           res_entry_ff, res_entry_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_have_ff, rsp_have_in;
   entry_type            rsp_entry_ff, rsp_entry_in;
   logic [FILL_W-1:0]    rsp_fill_ff, rsp_fill_in;
   logic [REMOVED_W-1:0] rsp_removed_ff, rsp_removed_in;

   logic pass_more;
   logic pass_end;
   logic hit;
   logic drop;
   logic rsp_free;

   assign req_tready    = (state_ff == S_IDLE);
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_valid = rsp_have_ff;
   assign rsp_entry     = rsp_entry_ff;
   assign rsp_fill      = rsp_fill_ff;
   assign rsp_removed   = rsp_removed_ff;

   assign pass_more = (ri_ff < cnt_ff);
   assign pass_end  = !pass_more && !dv_ff;
   assign hit       = (ram_rdata.ev_type == new_ff.ev_type);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      new_in         = new_ff;
      cnt_in         = cnt_ff;
      ri_in          = ri_ff;
      dv_in          = dv_ff;
      di_in          = di_ff;
      wp_in          = wp_ff;
      rm_in          = rm_ff;
      lock_in        = lock_ff;
      ins_done_in    = ins_done_ff;
      carry_in       = carry_ff;
      res_status_in  = res_status_ff;
      res_have_in    = res_have_ff;
      res_entry_in   = res_entry_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_have_in    = rsp_have_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_removed_in = rsp_removed_ff;
      drop           = 1'b0;

      ram_req.we    = 1'b0;
      ram_req.waddr = '0;
      ram_req.wdata = carry_ff;
      ram_req.raddr = ri_ff[ADDR_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in       = req_kind;
               new_in        = req_entry;
               rm_in         = '0;
               res_status_in = ST_OK;
               res_have_in   = 1'b0;
               res_entry_in  = '0;
               state_in      = S_DECODE;
            end
         end

         S_DECODE: begin
            ri_in   = '0;
            dv_in   = 1'b0;
            wp_in   = '0;
            lock_in = 1'b0;
            case (kind_ff)
               KIND_ADD: state_in = S_INS_CHK;
               KIND_POP: begin
                  if (cnt_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_DROP;
                  end
               end
               KIND_RM_ONE: begin
                  if (cnt_ff == '0) begin
                     state_in = S_HEAD_RD;
                  end else if (!masks.single_mask[new_ff.ev_type]) begin
                     res_status_in = ST_NOT_ALLOWED;
                     state_in      = S_HEAD_RD;
                  end else begin
                     state_in = S_DROP;
                  end
               end
               KIND_RM_ALL: begin
                  if (cnt_ff == '0) begin
                     state_in = S_HEAD_RD;
                  end else if (!masks.multi_mask[new_ff.ev_type]) begin
                     res_status_in = ST_NOT_ALLOWED;
                     state_in      = S_HEAD_RD;
                  end else begin
                     state_in = S_DROP;
                  end
               end
               KIND_REPLACE: state_in = S_DROP;
               default:      state_in = S_HEAD_RD;
            endcase
         end

         S_DROP: begin
            if (pass_more) begin
               ri_in = ri_ff + 1'b1;
            end
            dv_in = pass_more;
            di_in = ri_ff[ADDR_W-1:0];
            if (dv_ff) begin
               if (kind_ff == KIND_POP) begin
                  drop = (di_ff == '0);
               end else begin
                  drop = (di_ff != '0) && hit && !lock_ff;
               end
               // head of the walk carries the type, so remove one stops here
               if ((di_ff == '0) && (kind_ff == KIND_RM_ONE) && hit) begin
                  lock_in = 1'b1;
               end
               if (drop) begin
                  rm_in = rm_ff + 1'b1;
                  if (kind_ff != KIND_RM_ALL) begin
                     lock_in = 1'b1;
                  end
                  if (kind_ff == KIND_POP) begin
                     res_have_in  = 1'b1;
                     res_entry_in = ram_rdata;
                  end
               end else begin
                  if (wp_ff != di_ff) begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = wp_ff;
                     ram_req.wdata = ram_rdata;
                  end
                  wp_in = wp_ff + 1'b1;
               end
            end
            if (pass_end) begin
               cnt_in = cnt_ff - CNT_W'(rm_ff);
               if (kind_ff == KIND_POP) begin
                  state_in = S_DONE;
               end else if (kind_ff == KIND_REPLACE) begin
                  state_in = S_INS_CHK;
               end else begin
                  state_in = S_HEAD_RD;
               end
            end
         end

         S_INS_CHK: begin
            ri_in       = '0;
            dv_in       = 1'b0;
            ins_done_in = 1'b0;
            carry_in    = new_ff;
            if (new_ff.ev_time[TIME_BITS-1]) begin
               res_status_in = ST_NEG_TIME;
               state_in      = S_HEAD_RD;
            end else if (cnt_ff >= CNT_W'(QUEUE_DEPTH)) begin
               res_status_in = ST_FULL;
               state_in      = S_HEAD_RD;
            end else begin
               state_in = S_INS;
            end
         end

         S_INS: begin
            if (pass_more) begin
               ri_in = ri_ff + 1'b1;
            end
            dv_in = pass_more;
            di_in = ri_ff[ADDR_W-1:0];
            if (dv_ff) begin
               // one entry held back: everything from the insertion point moves up by one
               if (ins_done_ff || ($signed(new_ff.ev_time) < $signed(ram_rdata.ev_time))) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = di_ff;
                  ram_req.wdata = carry_ff;
                  carry_in      = ram_rdata;
                  ins_done_in   = 1'b1;
               end
            end
            if (pass_end) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = cnt_ff[ADDR_W-1:0];
               ram_req.wdata = carry_ff;
               cnt_in        = cnt_ff + 1'b1;
               state_in      = S_HEAD_RD;
            end
         end

         S_HEAD_RD: begin
            ram_req.raddr = '0;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_HEAD_WAIT;
            end
         end

         S_HEAD_WAIT: begin
            res_have_in  = 1'b1;
            res_entry_in = ram_rdata;
            state_in     = S_DONE;
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_have_in   = res_have_ff;
               rsp_entry_in  = res_have_ff ? res_entry_ff : '0;
               rsp_fill_in   = FILL_W'(cnt_ff);
               if (kind_ff == KIND_POP) begin
                  rsp_removed_in = '0;
               end else begin
                  rsp_removed_in = REMOVED_W'(rm_ff);
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      new_ff         <= new_in;
      ri_ff          <= ri_in;
      di_ff          <= di_in;
      wp_ff          <= wp_in;
      rm_ff          <= rm_in;
      lock_ff        <= lock_in;
      ins_done_ff    <= ins_done_in;
      carry_ff       <= carry_in;
      res_status_ff  <= res_status_in;
      res_have_ff    <= res_have_in;
      res_entry_ff   <= res_entry_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_have_ff    <= rsp_have_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_removed_ff <= rsp_removed_in;
   end

endmodule

[src/setl_checker.sv]
module setl_checker import setl_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [STATUS_W-1:0]  status;
   logic                 out_valid;
   logic [FILL_W-1:0]    fill;
   logic [REMOVED_W-1:0] removed;

   assign status    = rsp_tuser[STATUS_W-1:0];
   assign out_valid = rsp_tuser[STATUS_W];
   assign fill      = rsp_tdata[RSP_FILL_LSB +: FILL_W];
   assign removed   = rsp_tdata[RSP_REM_LSB +: REMOVED_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> fill <= FILL_W'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   a_no_entry_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_valid |-> fill == '0 && rsp_tdata[RSP_FILL_LSB-1:0] == '0)
      else $error("no entry reported but queue not empty or fields not zero");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == ST_EMPTY |-> !out_valid && removed == '0)
      else $error("pop on empty queue reported an entry");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == ST_FULL |-> fill == FILL_W'(QUEUE_DEPTH) && removed == '0)
      else $error("full status with room left");

endmodule

bind sorted_event_timeline setl_checker u_checker (.*);
